[rtl/core/s2fd_pkg.sv]
// shared types, status codes and difference unpacking for the steim-2 frame decoder
package s2fd_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 16;
  localparam int unsigned DiffIdxW   = 17;
  localparam int unsigned FrameWords = 16;
  localparam int unsigned PosW       = $clog2(FrameWords);
  localparam int unsigned MaxDiffs   = 7;
  localparam int unsigned DiffCntW   = $clog2(MaxDiffs + 1);

  localparam logic [DiffIdxW-1:0] DiffSat = {DiffIdxW{1'b1}};
  localparam logic [PosW-1:0]     LastPos = PosW'(FrameWords - 1);

  // status codes carried on the result channel
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CODE = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_TOO_FEW  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_PARTIAL  = 3'd5;

  // packing of one data word, from its 2-bit code and its dnib
  typedef enum logic [3:0] {
    FMT_NONE = 4'd0,
    FMT_4X8  = 4'd1,
    FMT_1X30 = 4'd2,
    FMT_2X15 = 4'd3,
    FMT_3X10 = 4'd4,
    FMT_5X6  = 4'd5,
    FMT_6X5  = 4'd6,
    FMT_7X4  = 4'd7,
    FMT_BAD  = 4'd8
  } fmt_e;

  // controller to datapath strobes
  typedef struct packed {
    logic load;
    logic head;
    logic diff;
    logic endc;
    logic fin;
  } s2fd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic head_to_diff;
    logic diff_last;
    logic failed;
  } s2fd_stat_t;

  function automatic fmt_e fmt_of(input logic [1:0] code, input logic [1:0] dnib);
    fmt_e f;
    f = FMT_BAD;
    case (code)
      2'd0: f = FMT_NONE;
      2'd1: f = FMT_4X8;
      2'd2: begin
        case (dnib)
          2'd1:    f = FMT_1X30;
          2'd2:    f = FMT_2X15;
          2'd3:    f = FMT_3X10;
          default: f = FMT_BAD;
        endcase
      end
      default: begin
        case (dnib)
          2'd0:    f = FMT_5X6;
          2'd1:    f = FMT_6X5;
          2'd2:    f = FMT_7X4;
          default: f = FMT_BAD;
        endcase
      end
    endcase
    return f;
  endfunction

  function automatic logic [DiffCntW-1:0] fmt_count(input fmt_e f);
    logic [DiffCntW-1:0] n;
    case (f)
      FMT_4X8:  n = DiffCntW'(4);
      FMT_1X30: n = DiffCntW'(1);
      FMT_2X15: n = DiffCntW'(2);
      FMT_3X10: n = DiffCntW'(3);
      FMT_5X6:  n = DiffCntW'(5);
      FMT_6X5:  n = DiffCntW'(6);
      FMT_7X4:  n = DiffCntW'(7);
      default:  n = '0;
    endcase
    return n;
  endfunction

  // difference number i of a data word, sign-extended to 32 bits
  function automatic logic signed [WordW-1:0] diff_at(input logic [WordW-1:0] w,
                                                      input fmt_e f,
                                                      input logic [DiffCntW-1:0] i);
    int          ii;
    logic [4:0]  sh;
    logic [31:0] fld;
    logic signed [WordW-1:0] d;
    ii  = int'(i);
    sh  = '0;
    d   = '0;
    case (f)
      FMT_4X8:  sh = 5'(24 - 8 * ii);
      FMT_2X15: sh = 5'(15 - 15 * ii);
      FMT_3X10: sh = 5'(20 - 10 * ii);
      FMT_5X6:  sh = 5'(24 - 6 * ii);
      FMT_6X5:  sh = 5'(25 - 5 * ii);
      FMT_7X4:  sh = 5'(24 - 4 * ii);
      default:  sh = '0;
    endcase
    fld = w >> sh;
    case (f)
      FMT_4X8:  d = {{24{fld[7]}}, fld[7:0]};
      FMT_1X30: d = {{2{w[29]}}, w[29:0]};
      FMT_2X15: d = {{17{fld[14]}}, fld[14:0]};
      FMT_3X10: d = {{22{fld[9]}}, fld[9:0]};
      FMT_5X6:  d = {{26{fld[5]}}, fld[5:0]};
      FMT_6X5:  d = {{27{fld[4]}}, fld[4:0]};
      FMT_7X4:  d = {{28{fld[3]}}, fld[3:0]};
      default:  d = '0;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/steim2_frame_decoder_top.sv]
// top level of the steim-2 frame decoder: configuration registers, sequencer and datapath
//
// Decodes the data region of a steim-2 record, one 32-bit word per input request. Each word
// produces one or more result requests (up to eight); last_o marks the final one belonging to
// a word, and a word that decodes to nothing still gives one empty result (sample_valid_o low,
// status ok). record_start_i clears all record state before the word is used, and the word
// after one flagged record_end_i always begins a new record. A sequencer loads the word, handles
// the frame position, then steps a single 33-bit adder through the packed differences one per
// cycle while the output is not stalled, runs the end-of-record checks and flushes the last
// result. Results leave through an output register, and the next word is taken while the final
// result of the previous one still waits there. Errors (bad code, overflow, too few differences,
// end value mismatch, partial frame) appear as a result with the error status and sample_valid_o
// low, but for an end value mismatch on a difference, which keeps its sample; after one, a
// record gives only empty results until it ends. The user writes the declared sample total
// (offset 0) and big_endian_words (offset 4) through the apb port only while the block is
// idle; the block itself does not enforce it.
module steim2_frame_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input word channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [s2fd_pkg::WordW-1:0]          raw_word_i,
  input  logic                                record_start_i,
  input  logic                                record_end_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [s2fd_pkg::WordW-1:0]   sample_value_o,
  output logic                                sample_valid_o,
  output logic [2:0]                          status_o,
  output logic                                last_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import s2fd_pkg::*;

  localparam logic REG_NUM_SAMPLES = 1'b0;
  localparam logic REG_BIG_ENDIAN  = 1'b1;

  logic [CountW-1:0] n_samples_q;
  logic              big_endian_q;
  logic              cfg_wr;

  s2fd_cmd_t  cmd;
  s2fd_stat_t stat;

  // register write completes in the access phase; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_samples_q  <= '0;
      big_endian_q <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_SAMPLES: n_samples_q  <= pwdata[CountW-1:0];
        REG_BIG_ENDIAN:  big_endian_q <= pwdata[0];
        default:         n_samples_q  <= n_samples_q;
      endcase
    end
  end

  // readback of the two registers
  always_comb begin
    case (paddr[2])
      REG_NUM_SAMPLES: prdata = {{(32 - CountW){1'b0}}, n_samples_q};
      REG_BIG_ENDIAN:  prdata = {31'd0, big_endian_q};
      default:         prdata = '0;
    endcase
  end

  // sequencer: one word at a time, a step per cycle whenever the output side has room
  s2fd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // frame tracking, unpacking, integration and the output register
  s2fd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .n_samples_i        (n_samples_q),
    .big_endian_words_i (big_endian_q),
    .raw_word_i         (raw_word_i),
    .record_start_i     (record_start_i),
    .record_end_i       (record_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sample_value_o     (sample_value_o),
    .sample_valid_o     (sample_valid_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

endmodule

[rtl/core/s2fd_ctrl.sv]
// sequencer for the steim-2 frame decoder: word load, head, difference steps, end checks, flush
module s2fd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  s2fd_pkg::s2fd_stat_t stat_i,
  output s2fd_pkg::s2fd_cmd_t  cmd_o
);
  import s2fd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WORD = 5'b00010,
    S_DIFF = 5'b00100,
    S_ENDC = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WORD;
        end
      end
      S_WORD: begin
        if (stat_i.out_free) begin
          cmd_o.head = 1'b1;
          state_d    = stat_i.head_to_diff ? S_DIFF : S_ENDC;
        end
      end
      S_DIFF: begin
        if (stat_i.out_free) begin
          cmd_o.diff = 1'b1;
          if (stat_i.diff_last || stat_i.failed) begin
            state_d = S_ENDC;
          end
        end
      end
      S_ENDC: begin
        if (stat_i.out_free) begin
          cmd_o.endc = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/core/s2fd_datapath.sv]
// frame tracking, difference unpacking, integration, pending item and output register
module s2fd_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  s2fd_pkg::s2fd_cmd_t          cmd_i,
  output s2fd_pkg::s2fd_stat_t         stat_o,
  input  logic [s2fd_pkg::CountW-1:0]  n_samples_i,
  input  logic                         big_endian_words_i,
  input  logic [s2fd_pkg::WordW-1:0]   raw_word_i,
  input  logic                         record_start_i,
  input  logic                         record_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [s2fd_pkg::WordW-1:0] sample_value_o,
  output logic                         sample_valid_o,
  output logic [2:0]                   status_o,
  output logic                         last_o
);
  import s2fd_pkg::*;

  // per-word registers
  logic [WordW-1:0]    word_q;
  logic                rend_q;
  logic [DiffCntW-1:0] dcnt_q, dcnt_d;

  // record state
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     first_q, first_d;
  logic [15:0][1:0]         ctrl_q, ctrl_d;
  logic [WordW-1:0]         xn_q, xn_d;
  logic [WordW-1:0]         run_q, run_d;
  logic [DiffIdxW-1:0]      didx_q, didx_d;
  logic                     failed_q, failed_d;

  // pending item, held until it is known whether another item follows
  logic              pend_valid_q, pend_valid_d;
  logic [WordW-1:0]  pend_val_q, pend_val_d;
  logic              pend_vld_q, pend_vld_d;
  logic [2:0]        pend_st_q, pend_st_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_val_q;
  logic              out_vld_q;
  logic [2:0]        out_st_q;
  logic              out_last_q;

  logic              out_free;
  logic              push;
  logic [WordW-1:0]  push_val;
  logic              push_vld;
  logic [2:0]        push_st;
  logic              push_last;

  logic              gen;
  logic [WordW-1:0]  gen_val;
  logic              gen_vld;
  logic [2:0]        gen_st;

  logic [WordW-1:0]        swapped;
  logic [1:0]              code;
  fmt_e                    fmt;
  logic [DiffCntW-1:0]     nd;
  logic signed [WordW-1:0] dval;
  logic [WordW:0]          sum;
  logic                    ovf;
  logic                    in_range;
  logic [DiffIdxW-1:0]     sc_ext;
  logic                    special;

  assign swapped  = big_endian_words_i ? raw_word_i
                  : {raw_word_i[7:0], raw_word_i[15:8], raw_word_i[23:16], raw_word_i[31:24]};
  assign code     = ctrl_q[~pos_q];
  assign fmt      = fmt_of(code, word_q[31:30]);
  assign nd       = fmt_count(fmt);
  assign dval     = diff_at(word_q, fmt, dcnt_q);
  assign sum      = {run_q[WordW-1], run_q} + {dval[WordW-1], dval};
  assign ovf      = sum[WordW] ^ sum[WordW-1];
  assign sc_ext   = {1'b0, n_samples_i};
  assign in_range = (didx_q != '0) && (didx_q < sc_ext);
  assign special  = (pos_q == '0) || (first_q && ((pos_q == PosW'(1)) || (pos_q == PosW'(2))));
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.out_free     = out_free;
  assign stat_o.head_to_diff = !failed_q && !special && (nd != '0);
  assign stat_o.diff_last    = (dcnt_q == nd - DiffCntW'(1));
  assign stat_o.failed       = failed_q;

  always_comb begin
    pos_d        = pos_q;
    first_d      = first_q;
    ctrl_d       = ctrl_q;
    xn_d         = xn_q;
    run_d        = run_q;
    didx_d       = didx_q;
    failed_d     = failed_q;
    dcnt_d       = dcnt_q;
    gen          = 1'b0;
    gen_val      = '0;
    gen_vld      = 1'b0;
    gen_st       = ST_OK;

    if (cmd_i.load) begin
      dcnt_d = '0;
      if (record_start_i) begin
        pos_d    = '0;
        first_d  = 1'b1;
        ctrl_d   = '0;
        xn_d     = '0;
        run_d    = '0;
        didx_d   = '0;
        failed_d = 1'b0;
      end
    end

    if (cmd_i.head && !failed_q) begin
      if (pos_q == '0) begin
        ctrl_d = word_q;
      end else if (first_q && (pos_q == PosW'(1))) begin
        // first sample of the record
        run_d = word_q;
        if (n_samples_i != '0) begin
          gen     = 1'b1;
          gen_val = word_q;
          gen_vld = 1'b1;
        end
      end else if (first_q && (pos_q == PosW'(2))) begin
        // end constant; a one-sample record is checked right here
        xn_d = word_q;
        if ((n_samples_i == CountW'(1)) && (run_q != word_q)) begin
          gen      = 1'b1;
          gen_st   = ST_MISMATCH;
          failed_d = 1'b1;
        end
      end else if (fmt == FMT_BAD) begin
        gen      = 1'b1;
        gen_st   = ST_BAD_CODE;
        failed_d = 1'b1;
      end
    end

    if (cmd_i.diff && !failed_q) begin
      dcnt_d = dcnt_q + DiffCntW'(1);
      if (didx_q != DiffSat) begin
        didx_d = didx_q + DiffIdxW'(1);
      end
      if (in_range) begin
        gen = 1'b1;
        if (ovf) begin
          gen_st   = ST_OVERFLOW;
          failed_d = 1'b1;
        end else begin
          run_d   = sum[WordW-1:0];
          gen_val = sum[WordW-1:0];
          gen_vld = 1'b1;
          if ((didx_q + DiffIdxW'(1) == sc_ext) && (sum[WordW-1:0] != xn_q)) begin
            gen_st   = ST_MISMATCH;
            failed_d = 1'b1;
          end
        end
      end
    end

    if (cmd_i.endc) begin
      if (rend_q && !failed_q) begin
        if (pos_q != LastPos) begin
          gen    = 1'b1;
          gen_st = ST_PARTIAL;
        end else if ((n_samples_i > CountW'(1)) && (didx_q < sc_ext)) begin
          gen    = 1'b1;
          gen_st = ST_TOO_FEW;
        end
      end
      if (rend_q) begin
        pos_d    = '0;
        first_d  = 1'b1;
        ctrl_d   = '0;
        xn_d     = '0;
        run_d    = '0;
        didx_d   = '0;
        failed_d = 1'b0;
      end else begin
        if (pos_q == LastPos) begin
          first_d = 1'b0;
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // pending item and output register movement
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    pend_vld_d   = pend_vld_q;
    pend_st_d    = pend_st_q;
    push         = 1'b0;
    push_val     = pend_val_q;
    push_vld     = pend_vld_q;
    push_st      = pend_st_q;
    push_last    = 1'b0;
    if (gen) begin
      push         = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_val_d   = gen_val;
      pend_vld_d   = gen_vld;
      pend_st_d    = gen_st;
    end
    if (cmd_i.fin) begin
      push         = 1'b1;
      push_last    = 1'b1;
      pend_valid_d = 1'b0;
      if (!pend_valid_q) begin
        push_val = '0;
        push_vld = 1'b0;
        push_st  = ST_OK;
      end
    end
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      first_q      <= 1'b1;
      ctrl_q       <= '0;
      xn_q         <= '0;
      run_q        <= '0;
      didx_q       <= '0;
      failed_q     <= 1'b0;
      dcnt_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      first_q      <= first_d;
      ctrl_q       <= ctrl_d;
      xn_q         <= xn_d;
      run_q        <= run_d;
      didx_q       <= didx_d;
      failed_q     <= failed_d;
      dcnt_q       <= dcnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= swapped;
      rend_q <= record_end_i;
    end
    pend_val_q <= pend_val_d;
    pend_vld_q <= pend_vld_d;
    pend_st_q  <= pend_st_d;
    if (push) begin
      out_val_q  <= push_val;
      out_vld_q  <= push_vld;
      out_st_q   <= push_st;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_val_q;
  assign sample_valid_o = out_vld_q;
  assign status_o       = out_st_q;
  assign last_o         = out_last_q;

  // the flush step always leaves the pending slot empty
  a_fin_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> !pend_valid_q)
    else $error("pending item survived the flush step");

  // the difference count only moves forward inside a record
  a_didx_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && record_start_i) && !(cmd_i.endc && rend_q) |=> didx_q >= $past(didx_q))
    else $error("difference index went backward inside a record");

  // a failed record generates no further items in its head, difference or end-check steps
  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && (cmd_i.head || cmd_i.diff || cmd_i.endc) |-> !gen)
    else $error("item generated after the record failed");

  // a sample carries only ok or end mismatch
  a_sample_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_vld_q |-> (out_st_q == ST_OK) || (out_st_q == ST_MISMATCH))
    else $error("sample item with an error status");

endmodule

[verif/tb_steim2_frame_decoder_top.sv]
// self-checking testbench for the steim-2 frame decoder top level
module tb_steim2_frame_decoder_top;
  import s2fd_pkg::*;

  // register offsets on the apb port
  localparam logic [2:0] REG_NUM_SAMPLES = 3'd0;
  localparam logic [2:0] REG_BIG_ENDIAN  = 3'd4;

  // 2-bit steim-2 word codes held in the control word
  localparam logic [1:0] SC_NONE  = 2'd0;
  localparam logic [1:0] SC_BYTES = 2'd1;
  localparam logic [1:0] SC_LONG  = 2'd2;
  localparam logic [1:0] SC_SHORT = 2'd3;

  typedef struct {
    logic [31:0] raw;
    logic        rs;
    logic        re;
  } word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               valid;
    logic [2:0]         status;
    logic               last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [31:0] raw_word = '0;
  logic        rec_start = 1'b0;
  logic        rec_end = 1'b0;
  logic        out_valid_o;
  logic        out_stall;
  logic        burst_stall = 1'b0;
  logic        hold_on = 1'b0;
  logic signed [31:0] sample_value_o;
  logic        sample_valid_o;
  logic [2:0]  status_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // words still to be offered, and results the decoder still owes
  word_t   pending_words[$];
  result_t due_results[$];

  int  fail_count = 0;
  int  words_queued = 0;
  int  idle_pct = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  hold_req = 1'b0;
  logic in_took = 1'b0;

  // shadow of the configuration registers
  logic [15:0] cfg_count;
  logic        cfg_be;

  // decoder state as it should be
  logic [3:0]         st_pos;
  logic               st_first;
  logic [31:0]        st_ctrl;
  logic [31:0]        st_xn;
  logic signed [31:0] st_run;
  logic [16:0]        st_didx;
  logic               st_failed;

  assign out_stall = burst_stall | hold_on;

  steim2_frame_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .raw_word_i     (raw_word),
    .record_start_i (rec_start),
    .record_end_i   (rec_end),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .sample_value_o (sample_value_o),
    .sample_valid_o (sample_valid_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // packing of a data word from its code and its top two bits
  function automatic fmt_e pick_fmt(input logic [1:0] code, input logic [1:0] dnib);
    case (code)
      SC_NONE:  return FMT_NONE;
      SC_BYTES: return FMT_4X8;
      SC_LONG:  return (dnib == 2'd1) ? FMT_1X30 : (dnib == 2'd2) ? FMT_2X15 :
                       (dnib == 2'd3) ? FMT_3X10 : FMT_BAD;
      default:  return (dnib == 2'd0) ? FMT_5X6 : (dnib == 2'd1) ? FMT_6X5 :
                       (dnib == 2'd2) ? FMT_7X4 : FMT_BAD;
    endcase
  endfunction

  function automatic longint sext_field(input logic [31:0] v, input int bits);
    longint x;
    x = longint'(v & ((32'd1 << bits) - 32'd1));
    if (v[bits-1]) x = x - (longint'(1) << bits);
    return x;
  endfunction

  // differences carried by one data word, -1 for an illegal packing
  function automatic int split_diffs(input logic [31:0] w, input logic [1:0] code,
                                     output longint d[7]);
    int n, top, width, i;
    n = 0;
    top = 0;
    width = 30;
    case (pick_fmt(code, w[31:30]))
      FMT_NONE: n = 0;
      FMT_4X8:  begin n = 4; top = 24; width = 8;  end
      FMT_1X30: begin n = 1; top = 0;  width = 30; end
      FMT_2X15: begin n = 2; top = 15; width = 15; end
      FMT_3X10: begin n = 3; top = 20; width = 10; end
      FMT_5X6:  begin n = 5; top = 24; width = 6;  end
      FMT_6X5:  begin n = 6; top = 25; width = 5;  end
      FMT_7X4:  begin n = 7; top = 24; width = 4;  end
      default:  n = -1;
    endcase
    for (i = 0; i < 7; i++) d[i] = 0;
    for (i = 0; i < n; i++) d[i] = sext_field(w >> (top - i * width), width);
    return n;
  endfunction

  function automatic void clear_record();
    st_pos    = '0;
    st_first  = 1'b1;
    st_ctrl   = '0;
    st_xn     = '0;
    st_run    = '0;
    st_didx   = '0;
    st_failed = 1'b0;
  endfunction

  function automatic result_t make_result(input logic [31:0] v, input logic ok,
                                          input logic [2:0] st);
    result_t r;
    r.value  = v;
    r.valid  = ok;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

  // works out the results of one accepted word and queues them
  task automatic decode_word(input logic [31:0] raw, input logic rs, input logic re);
    logic [31:0] w;
    logic [3:0]  pos;
    logic [1:0]  code;
    longint      d[7];
    longint      nxt;
    logic [16:0] idx;
    int          n, i;
    result_t     grp[$];
    if (rs) clear_record();
    w = cfg_be ? raw : swap_bytes(raw);
    pos = st_pos;
    if (!st_failed) begin
      if (pos == 4'd0) begin
        st_ctrl = w;
      end else if (st_first && pos == 4'd1) begin
        // first sample goes out as soon as it arrives
        st_run = w;
        if (cfg_count >= 16'd1) grp.insert(grp.size(), make_result(w, 1'b1, ST_OK));
      end else if (st_first && pos == 4'd2) begin
        st_xn = w;
        // a single-sample record is checked right here
        if (cfg_count == 16'd1 && st_run != st_xn) begin
          grp.insert(grp.size(), make_result('0, 1'b0, ST_MISMATCH));
          st_failed = 1'b1;
        end
      end else begin
        code = 2'((st_ctrl >> (30 - 2 * int'(pos))) & 32'h3);
        n = split_diffs(w, code, d);
        if (n < 0) begin
          grp.insert(grp.size(), make_result('0, 1'b0, ST_BAD_CODE));
          st_failed = 1'b1;
        end
        for (i = 0; i < n && !st_failed; i++) begin
          idx = st_didx;
          if (st_didx != DiffSat) st_didx = st_didx + 17'd1;
          // difference zero and surplus ones are only counted
          if (idx >= 17'd1 && idx < {1'b0, cfg_count}) begin
            nxt = longint'(st_run) + d[i];
            if (nxt != longint'(signed'(nxt[31:0]))) begin
              grp.insert(grp.size(), make_result('0, 1'b0, ST_OVERFLOW));
              st_failed = 1'b1;
            end else begin
              st_run = nxt[31:0];
              if (idx + 17'd1 == {1'b0, cfg_count} && st_run != st_xn) begin
                grp.insert(grp.size(), make_result(st_run, 1'b1, ST_MISMATCH));
                st_failed = 1'b1;
              end else begin
                grp.insert(grp.size(), make_result(st_run, 1'b1, ST_OK));
              end
            end
          end
        end
      end
      // end of record checks, partial frame first
      if (re && !st_failed) begin
        if (pos != LastPos)
          grp.insert(grp.size(), make_result('0, 1'b0, ST_PARTIAL));
        else if (cfg_count > 16'd1 && st_didx < {1'b0, cfg_count})
          grp.insert(grp.size(), make_result('0, 1'b0, ST_TOO_FEW));
      end
    end
    if (grp.size() == 0) grp.insert(0, make_result('0, 1'b0, ST_OK));
    grp[grp.size()-1].last = 1'b1;
    foreach (grp[i]) due_results.insert(due_results.size(), grp[i]);
    if (re) begin
      clear_record();
    end else begin
      if (pos == LastPos) st_first = 1'b0;
      st_pos = pos + 4'd1;
    end
  endtask

  // acceptance of an input request, and prediction of what it causes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) decode_word(raw_word, rec_start, rec_end);
    end
  end

  // sender: holds a request until taken, idles in random bursts
  always @(negedge clk_i) begin : word_driver
    word_t nw;
    if (rst_ni) begin
      if (in_valid && !in_took) begin
        // stalled request stays as it is
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 9);
      end else if (pending_words.size() != 0) begin
        nw = pending_words.pop_front();
        in_valid  <= 1'b1;
        raw_word  <= nw.raw;
        rec_start <= nw.rs;
        rec_end   <= nw.re;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      burst_stall <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      burst_stall <= 1'b1;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      burst_stall <= 1'b0;
    end
  end

  // long receiver hold-off, so the decoder backs up into its input
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_on = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_on = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: sample_value %0d status %0d", sample_value_o, status_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (sample_value_o !== want.value) begin
          $error("sample_value: expected %0d, got %0d", want.value, sample_value_o);
          fail_count++;
        end
        if (sample_valid_o !== want.valid) begin
          $error("sample_valid: expected %0d, got %0d", want.valid, sample_valid_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  function automatic void add_word(input logic [31:0] raw, input logic rs, input logic re);
    word_t w;
    w.raw = raw;
    w.rs  = rs;
    w.re  = re;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endfunction

  // register write followed by a read back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_NUM_SAMPLES) cfg_count = data[15:0];
    else cfg_be = data[0];
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_NUM_SAMPLES && got[15:0] !== data[15:0]) begin
      $error("num_samples: expected %0d, got %0d", data[15:0], got[15:0]);
      fail_count++;
    end
    if (addr == REG_BIG_ENDIAN && got[0] !== data[0]) begin
      $error("big_endian_words: expected %0d, got %0d", data[0], got[0]);
      fail_count++;
    end
  endtask

  // one record of whole frames with random packings and an end value that mostly matches;
  // a sloppy record has more bad packings and may be cut short
  task automatic queue_record(input bit sloppy);
    logic [31:0] body[$];
    logic [31:0] ctrl, w, x0, xn;
    logic [1:0]  code, dnib;
    longint      acc;
    longint      dl[7];
    int          nd, diffs, fr, pos, i, base, cut, bad_pct;
    logic        rs;
    bad_pct = sloppy ? 30 : 1;
    diffs = 0;
    fr = 0;
    x0 = $urandom();
    if ($urandom_range(0, 3) != 0) x0 = {{8{x0[23]}}, x0[23:0]};
    acc = longint'(signed'(x0));
    do begin
      base = body.size();
      body.insert(body.size(), 32'd0);
      ctrl = {2'($urandom_range(0, 3)), 30'd0};
      for (pos = 1; pos < 16; pos++) begin
        if (fr == 0 && pos == 1) begin
          body.insert(body.size(), x0);
        end else if (fr == 0 && pos == 2) begin
          body.insert(body.size(), 32'd0);
        end else begin
          do begin
            code = 2'($urandom_range(0, 3));
            dnib = 2'($urandom_range(0, 3));
          end while (pick_fmt(code, dnib) == FMT_BAD && $urandom_range(0, 99) >= bad_pct);
          w = $urandom();
          if (code == SC_LONG || code == SC_SHORT) w[31:30] = dnib;
          ctrl = ctrl | (32'(code) << (30 - 2 * pos));
          nd = split_diffs(w, code, dl);
          for (i = 0; i < nd; i++) begin
            if (diffs >= 1 && diffs < int'(cfg_count)) acc = acc + dl[i];
            diffs++;
          end
          body.insert(body.size(), w);
        end
      end
      body[base] = ctrl;
      fr++;
    end while (diffs < int'(cfg_count) && fr < 3);
    xn = acc[31:0];
    if ($urandom_range(0, 9) == 0) xn = xn ^ (32'd1 << $urandom_range(0, 31));
    body[2] = xn;
    cut = sloppy ? $urandom_range(1, body.size()) : body.size();
    rs = ($urandom_range(0, 3) != 0);
    for (i = 0; i < cut; i++)
      add_word(cfg_be ? body[i] : swap_bytes(body[i]), rs && i == 0, i == cut - 1);
  endtask

  task automatic queue_noise();
    int n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      add_word($urandom(), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] count, input logic be, input int n_words,
                           input int idle, input bit hold);
    int first, r;
    write_reg(REG_NUM_SAMPLES, 32'(count));
    write_reg(REG_BIG_ENDIAN, 32'(be));
    idle_pct = idle;
    if (hold) hold_req = 1'b1;
    first = words_queued;
    while (words_queued - first < n_words) begin
      r = $urandom_range(0, 9);
      if (r < 7) queue_record(1'b0);
      else if (r < 9) queue_record(1'b1);
      else queue_noise();
    end
    wait_drained();
  endtask

  initial begin
    cfg_count = '0;
    cfg_be    = 1'b1;
    clear_record();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed records with three samples declared, big-endian words
    write_reg(REG_NUM_SAMPLES, 32'd3);
    write_reg(REG_BIG_ENDIAN, 32'd1);
    idle_pct = 20;
    // code 2 with dnib 0 is illegal
    add_word(32'h0200_0000, 1'b1, 1'b0);
    add_word(32'h0000_0010, 1'b0, 1'b0);
    add_word(32'h0000_0010, 1'b0, 1'b0);
    add_word(32'h0000_0005, 1'b0, 1'b1);
    // code 3 with dnib 3 is illegal; record opened by the previous end
    add_word(32'h0300_0000, 1'b0, 1'b0);
    add_word(32'h0000_0001, 1'b0, 1'b0);
    add_word(32'h0000_0001, 1'b0, 1'b0);
    add_word(32'hC000_0000, 1'b0, 1'b1);
    // positive overflow from the largest first sample
    add_word(32'h0200_0000, 1'b1, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_word(32'h0000_0000, 1'b0, 1'b0);
    add_word(32'h8000_0001, 1'b0, 1'b1);
    // negative overflow from the smallest first sample
    add_word(32'h0200_0000, 1'b0, 1'b0);
    add_word(32'h8000_0000, 1'b0, 1'b0);
    add_word(32'h8000_0000, 1'b0, 1'b0);
    add_word(32'h8000_7FFF, 1'b0, 1'b1);
    // start and end on one word, ends as a partial frame
    add_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    // byte differences, end value matches, then a partial frame
    add_word(32'h0100_0000, 1'b1, 1'b0);
    add_word(32'h0000_0064, 1'b0, 1'b0);
    add_word(32'h0000_0067, 1'b0, 1'b0);
    add_word(32'h0001_02FF, 1'b0, 1'b1);
    // same record with a wrong end value
    add_word(32'h0100_0000, 1'b1, 1'b0);
    add_word(32'h0000_0064, 1'b0, 1'b0);
    add_word(32'h0000_0068, 1'b0, 1'b0);
    add_word(32'h0001_02FF, 1'b0, 1'b1);
    wait_drained();

    // random records over a spread of settings
    run_phase(16'd0, 1'b1, 40, 25, 1'b0);
    run_phase(16'd1, 1'b0, 40, 20, 1'b0);
    run_phase(16'd2, 1'b1, 40, 0, 1'b0);
    run_phase(16'd25, 1'b0, 40, 15, 1'b1);
    run_phase(16'hFFFF, 1'b1, 35, 25, 1'b0);
    run_phase(16'($urandom_range(3, 100)), 1'($urandom_range(0, 1)), 40, 30, 1'b0);
    // tail of the run without idling
    run_phase(16'd40, 1'b1, 35, 0, 1'b0);

    if (fail_count == 0) begin
      $display("tb_steim2_frame_decoder_top: PASS");
    end else begin
      $display("tb_steim2_frame_decoder_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_steim2_frame_decoder_top: FAIL");
    $finish;
  end

endmodule
